// File: design/mtbr_pkg.sv
// Shared constants, types and register codes of the bright-run extractor.
`timescale 1ns / 1ps
`default_nettype none

package mtbr_pkg;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  localparam int DIM_W  = 11;  // frame_width / frame_height registers
  localparam int SUM_W  = 28;  // channel sums
  localparam int AREA_W = 2 * DIM_W;
  localparam int PIX_W  = 8;
  localparam int LIM_W  = 9;   // signed thresholds
  localparam int NUM_CH = 3;

  localparam int START_W = 10;
  localparam int ROW_W_O = 10;
  localparam int LEN_W   = 11;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [SUM_W-1:0]  dividend;
    logic [AREA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic step;
    logic dark;
  } scan_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic frame_end;
  } scan_sts_t;

endpackage

`default_nettype wire

// File: design/mtbr_div.sv
// Restoring divider, one quotient bit per cycle, shared over the three channels.
`timescale 1ns / 1ps
`default_nettype none

module mtbr_div
  import mtbr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;    // dividend shifts out, quotient shifts in
  logic [AREA_W-1:0] rem_q, rem_d;
  logic [AREA_W-1:0] dsr_q, dsr_d;
  logic [AREA_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W);
      dvd_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? AREA_W'(trial - {1'b0, dsr_q}) : trial[AREA_W-1:0];
      dvd_d = {dvd_q[SUM_W-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

// File: design/mtbr_runs.sv
// Scan position, run tracking and the output word register.
`timescale 1ns / 1ps
`default_nettype none

module mtbr_runs
  import mtbr_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire scan_cmd_t        cmd_i,
  input  wire logic [DIM_W-1:0] width_i,
  input  wire logic [DIM_W-1:0] height_i,
  output scan_sts_t             sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [START_W-1:0]    run_start_o,
  output logic [ROW_W_O-1:0]    run_row_o,
  output logic [LEN_W-1:0]      run_length_o
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] dpos_q, dpos_d;
  logic [CNT_W-1:0] blen_q, blen_d;
  logic             ovld_q, ovld_d;
  logic [START_W-1:0] ostart_q, ostart_d;
  logic [ROW_W_O-1:0] orow_q, orow_d;
  logic [LEN_W-1:0]   olen_q, olen_d;

  logic [CNT_W-1:0] dpos1, blen1;
  logic             emit_dark, emit_end, row_end, last_row;

  always_comb begin
    emit_dark = cmd_i.dark && (blen_q != '0);
    dpos1     = cmd_i.dark ? CNT_W'(dpos_q + blen_q + CNT_W'(1)) : dpos_q;
    blen1     = cmd_i.dark ? '0 : CNT_W'(blen_q + CNT_W'(1));
    row_end   = (32'(col_q) + 32'd1) >= 32'(width_i);
    emit_end  = row_end && (blen1 != '0);
    last_row  = (32'(row_q) + 32'd1) >= 32'(height_i);
  end

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    dpos_d   = dpos_q;
    blen_d   = blen_q;
    ovld_d   = ovld_q && !out_ready_i;
    ostart_d = ostart_q;
    orow_d   = orow_q;
    olen_d   = olen_q;
    if (cmd_i.step) begin
      if (emit_dark || emit_end) begin
        ovld_d   = 1'b1;
        ostart_d = emit_dark ? START_W'(dpos_q) : START_W'(dpos1);
        orow_d   = ROW_W_O'(row_q);
        olen_d   = emit_dark ? LEN_W'(blen_q) : LEN_W'(blen1);
      end
      if (row_end) begin
        col_d  = '0;
        dpos_d = '0;
        blen_d = '0;
        row_d  = last_row ? '0 : ROW_W'(row_q + ROW_W'(1));
      end else begin
        col_d  = COL_W'(col_q + COL_W'(1));
        dpos_d = dpos1;
        blen_d = blen1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      dpos_q <= '0;
      blen_q <= '0;
      ovld_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      dpos_q <= dpos_d;
      blen_q <= blen_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostart_q <= ostart_d;
    orow_q   <= orow_d;
    olen_q   <= olen_d;
  end

  assign sts_o.slot_free = !ovld_q || out_ready_i;
  assign sts_o.frame_end = cmd_i.step && row_end && last_row;

  assign out_valid_o  = ovld_q;
  assign run_start_o  = ostart_q;
  assign run_row_o    = orow_q;
  assign run_length_o = olen_q;

endmodule

`default_nettype wire

// File: design/mean_threshold_bright_run_extractor.sv
// Top level: configuration port, channel sums, thresholds and the item sequencer.
// The input is not ready while a word is in work: an accumulate word passes
// through S_ACC, a scan word through S_SCAN, where it waits for the
// output register to free up. The first scan word of a frame also computes the
// three thresholds, through S_AREA, S_DIV_GO and S_DIV_WAIT, on one shared
// restoring divider that yields one quotient bit per cycle. Results sit in an
// output register, so the next word is taken while a run waits to be read.
// There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module mean_threshold_bright_run_extractor
  import mtbr_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic [PIX_W-1:0]  red_i,
  input  wire logic [PIX_W-1:0]  green_i,
  input  wire logic [PIX_W-1:0]  blue_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [START_W-1:0]     run_start_o,
  output logic [ROW_W_O-1:0]     run_row_o,
  output logic [LEN_W-1:0]       run_length_o
);

  localparam logic [DIM_W-1:0] COL_LIM = DIM_W'((MAX_COLS > 2047) ? 2047 : MAX_COLS);
  localparam logic [DIM_W-1:0] ROW_LIM = DIM_W'((MAX_ROWS > 2047) ? 2047 : MAX_ROWS);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ACC      = 6'b000010,
    S_AREA     = 6'b000100,
    S_DIV_GO   = 6'b001000,
    S_DIV_WAIT = 6'b010000,
    S_SCAN     = 6'b100000
  } state_e;

  function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] s, logic [PIX_W-1:0] v);
    logic [SUM_W:0] t;
    t = {1'b0, s} + (SUM_W + 1)'(v);
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  function automatic logic below(logic [PIX_W-1:0] v, logic signed [LIM_W-1:0] lim);
    return $signed({2'b00, v}) < $signed({lim[LIM_W-1], lim});
  endfunction

  state_e state_q, state_d;

  logic [DIM_W-1:0] fwidth_q, fheight_q;
  logic [DIM_W-1:0] width_c, height_c;
  logic             cfg_wr;

  logic [PIX_W-1:0] pix_q [NUM_CH];
  logic [SUM_W-1:0] sum_q [NUM_CH];
  logic [SUM_W-1:0] sum_d [NUM_CH];
  logic signed [LIM_W-1:0] lim_q [NUM_CH];
  logic signed [LIM_W-1:0] lim_d [NUM_CH];
  logic             ready_q, ready_d;   // thresholds valid for this frame
  logic [1:0]       ch_q, ch_d;
  logic [AREA_W-1:0] area_q;

  logic [PIX_W-1:0]    mean;
  logic [PIX_W-2:0]    half;
  logic signed [LIM_W-1:0] lim_new;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  scan_cmd_t scan_cmd;
  scan_sts_t scan_sts;

  // Configuration port
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? DATA_W'(fheight_q) : DATA_W'(fwidth_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwidth_q  <= DIM_W'(640);
      fheight_q <= DIM_W'(480);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        fwidth_q <= pwdata[DIM_W-1:0];
      end else begin
        fheight_q <= pwdata[DIM_W-1:0];
      end
    end
  end

  // A zero dimension counts as one, a large one as the maximum
  assign width_c  = (fwidth_q == '0) ? DIM_W'(1) :
                    ((fwidth_q > COL_LIM) ? COL_LIM : fwidth_q);
  assign height_c = (fheight_q == '0) ? DIM_W'(1) :
                    ((fheight_q > ROW_LIM) ? ROW_LIM : fheight_q);

  // Threshold from the divider's quotient
  always_comb begin
    mean = (div_rsp.quotient[SUM_W-1:PIX_W] != '0) ? '1 : div_rsp.quotient[PIX_W-1:0];
    half = 7'((8'd255 - mean) >> 1);
    if (ch_q == CH_RED) begin
      lim_new = $signed({1'b0, mean} + LIM_W'(half));
    end else begin
      lim_new = $signed({1'b0, mean} - LIM_W'(half));
    end
  end

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    ch_d    = ch_q;
    sum_d   = sum_q;
    lim_d   = lim_q;
    div_req.start    = 1'b0;
    div_req.dividend = sum_q[ch_q];
    div_req.divisor  = area_q;
    scan_cmd.step    = 1'b0;
    scan_cmd.dark    = below(pix_q[CH_RED], lim_q[CH_RED]) ||
                       below(pix_q[CH_GREEN], lim_q[CH_GREEN]) ||
                       below(pix_q[CH_BLUE], lim_q[CH_BLUE]);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!opcode_i) begin
            state_d = S_ACC;
          end else if (ready_q) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_AREA;
            ch_d    = CH_RED;
          end
        end
      end
      S_ACC: begin
        for (int c = 0; c < NUM_CH; c++) begin
          sum_d[c] = sat_add(sum_q[c], pix_q[c]);
        end
        state_d = S_IDLE;
      end
      S_AREA: begin
        state_d = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!div_rsp.busy) begin
          lim_d[ch_q] = lim_new;
          if (ch_q == CH_BLUE) begin
            for (int c = 0; c < NUM_CH; c++) begin
              sum_d[c] = '0;
            end
            ready_d = 1'b1;
            state_d = S_SCAN;
          end else begin
            ch_d    = ch_q + 2'd1;
            state_d = S_DIV_GO;
          end
        end
      end
      S_SCAN: begin
        // hold until the output register can take a word
        if (scan_sts.slot_free) begin
          scan_cmd.step = 1'b1;
          state_d       = S_IDLE;
          if (scan_sts.frame_end) begin
            ready_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
      ch_q    <= CH_RED;
      for (int c = 0; c < NUM_CH; c++) begin
        sum_q[c] <= '0;
        lim_q[c] <= '0;
      end
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      ch_q    <= ch_d;
      sum_q   <= sum_d;
      lim_q   <= lim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      pix_q[CH_RED]    <= red_i;
      pix_q[CH_GREEN]  <= green_i;
      pix_q[CH_BLUE]   <= blue_i;
    end
    if (state_q == S_AREA) begin
      area_q <= AREA_W'(width_c) * AREA_W'(height_c);
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  mtbr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  mtbr_runs #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_runs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (scan_cmd),
    .width_i      (width_c),
    .height_i     (height_c),
    .sts_o        (scan_sts),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .run_start_o  (run_start_o),
    .run_row_o    (run_row_o),
    .run_length_o (run_length_o)
  );

endmodule

`default_nettype wire

// File: design/mtbr_checker.sv
// Port-level checks on the bright-run extractor, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mtbr_checker
  import mtbr_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [START_W-1:0] run_start_o,
  input wire logic [ROW_W_O-1:0] run_row_o,
  input wire logic [LEN_W-1:0]   run_length_o
);

  // A stalled run word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(run_start_o) &&
      $stable(run_row_o) && $stable(run_length_o))
    else $error("stalled run word changed");

  // One word at a time: the input drops ready after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready straight after an accepted word");

  // A reported run is never empty
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> run_length_o != '0)
    else $error("run of zero length reported");

endmodule

bind mean_threshold_bright_run_extractor mtbr_checker u_mtbr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .run_start_o  (run_start_o),
  .run_row_o    (run_row_o),
  .run_length_o (run_length_o)
);

`default_nettype wire
